// ===== rtl/distinct_value_table_macros.svh =====
// Assertion macros used by the block's datapath module.
`ifndef DISTINCT_VALUE_TABLE_MACROS_SVH
`define DISTINCT_VALUE_TABLE_MACROS_SVH

// Concurrent check on a named clock and reset.
`define DVT_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent check on the block clock and reset.
`define DVT_ASSERT(lbl, prop, msg) \
   `DVT_ASSERT_CLK(lbl, clock, reset, prop, msg)

`endif

// ===== rtl/dvt_pkg.sv =====
package dvt_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int VALUE_W     = 31;
   localparam int SUM_W       = VALUE_W + IDX_W;
   localparam int FRAC_W      = 8;
   localparam int DIVD_W      = SUM_W + FRAC_W;
   localparam int STEP_W      = $clog2(DIVD_W + 1);

   localparam int POS_W       = 5;
   localparam int COUNT_W     = 6;
   localparam int MEAN_W      = 39;
   localparam int REQ_DATA_W  = 32;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_DATA_W  = 56;
   localparam int RSP_USER_W  = 3;
   localparam int RSP_PAD_W   = RSP_DATA_W - POS_W - COUNT_W - MEAN_W;

   typedef enum logic [REQ_USER_W-1:0] {
      REQ_INSERT = 2'd0,
      REQ_SEARCH = 2'd1,
      REQ_MEAN   = 2'd2,
      REQ_CLEAR  = 2'd3
   } req_kind_type;

   typedef enum logic [RSP_USER_W-1:0] {
      ST_INSERTED   = 3'd0,
      ST_DUPLICATE  = 3'd1,
      ST_FULL       = 3'd2,
      ST_FOUND      = 3'd3,
      ST_NOT_FOUND  = 3'd4,
      ST_MEAN_VALID = 3'd5,
      ST_EMPTY      = 3'd6,
      ST_CLEARED    = 3'd7
   } rsp_status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DIVIDE,
      S_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic div_start;
      logic finish;
   } dvt_cmd_type;

   typedef struct packed {
      logic hit;
      logic scan_done;
      logic empty;
      logic div_done;
      logic out_free;
   } dvt_status_type;

endpackage

// ===== rtl/distinct_value_table.sv =====
// Table of up to 32 distinct 31-bit values held in arrival order, with insert, search,
// mean and clear requests, one result transfer per request. Requests are taken one at a
// time; a new one is accepted while the previous result still waits on rsp_tready.
// Insert and search walk the filled entries through the single read port of the entry
// memory, one entry a cycle, stopping at the first match. Mean runs a 44-step
// restoring divider (one quotient bit a cycle); mean of an empty table and clear go
// straight to the result. Entries need no clearing after reset: only positions below
// the fill count are ever compared.
module distinct_value_table (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [dvt_pkg::REQ_DATA_W-1:0]    req_tdata,   // value[30:0], zero[31]
   input  logic [dvt_pkg::REQ_USER_W-1:0]    req_tuser,   // req_type[1:0]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [dvt_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // position[4:0], entry_count[10:5],
                                                          // mean_q8[49:11], zero[55:50]
   output logic [dvt_pkg::RSP_USER_W-1:0]    rsp_tuser    // status[2:0]
);

   dvt_pkg::dvt_cmd_type     cmd;
   dvt_pkg::dvt_status_type  status;
   dvt_pkg::req_kind_type    req_kind;

   assign req_kind = dvt_pkg::req_kind_type'(req_tuser);

   dvt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_kind),
      .status     (status),
      .cmd        (cmd)
   );

   dvt_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_kind   (req_kind),
      .req_value  (req_tdata[dvt_pkg::VALUE_W-1:0]),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== rtl/dvt_divider.sv =====
module dvt_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [dvt_pkg::DIVD_W-1:0]    dividend,
   input  logic [dvt_pkg::CNT_W-1:0]     divisor,
   output logic                          done,
   output logic [dvt_pkg::DIVD_W-1:0]    quotient
);

   logic                          busy_ff;
   logic [dvt_pkg::STEP_W-1:0]    step_ff;
   logic [dvt_pkg::DIVD_W-1:0]    quo_ff;
   logic [dvt_pkg::DIVD_W-1:0]    quo_in;
   logic [dvt_pkg::CNT_W-1:0]     rem_ff;
   logic [dvt_pkg::CNT_W-1:0]     rem_in;
   logic [dvt_pkg::CNT_W-1:0]     dsr_ff;
   logic [dvt_pkg::CNT_W:0]       shifted;
   logic [dvt_pkg::CNT_W:0]       diff;
   logic                          fits;

   // restoring step: remainder stays below the divisor, so it fits CNT_W bits
   always_comb begin
      shifted = {rem_ff, quo_ff[dvt_pkg::DIVD_W-1]};
      diff    = shifted - {1'b0, dsr_ff};
      fits    = (shifted >= {1'b0, dsr_ff});
      rem_in  = fits ? diff[dvt_pkg::CNT_W-1:0] : shifted[dvt_pkg::CNT_W-1:0];
      quo_in  = {quo_ff[dvt_pkg::DIVD_W-2:0], fits};
   end

   assign done     = busy_ff && (step_ff == dvt_pkg::STEP_W'(dvt_pkg::DIVD_W));
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         step_ff <= '0;
      end else if (done) begin
         busy_ff <= 1'b0;
      end else if (busy_ff) begin
         step_ff <= step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff && !done) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

endmodule

// ===== rtl/dvt_datapath.sv =====
`include "distinct_value_table_macros.svh"

module dvt_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  dvt_pkg::req_kind_type             req_kind,
   input  logic [dvt_pkg::VALUE_W-1:0]       req_value,
   input  dvt_pkg::dvt_cmd_type              cmd,
   output dvt_pkg::dvt_status_type           status,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [dvt_pkg::RSP_USER_W-1:0]    rsp_tuser,
   output logic [dvt_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   logic [dvt_pkg::VALUE_W-1:0]   mem [dvt_pkg::TABLE_DEPTH];
   logic [dvt_pkg::VALUE_W-1:0]   rd_data_ff;

   dvt_pkg::req_kind_type         kind_ff;
   logic [dvt_pkg::VALUE_W-1:0]   value_ff;
   logic [dvt_pkg::CNT_W-1:0]     fill_ff;
   logic [dvt_pkg::CNT_W-1:0]     fill_in;
   logic [dvt_pkg::SUM_W-1:0]     sum_ff;
   logic [dvt_pkg::SUM_W-1:0]     sum_in;

   logic [dvt_pkg::CNT_W-1:0]     rd_idx_ff;
   logic                          cmp_vld_ff;
   logic [dvt_pkg::IDX_W-1:0]     cmp_idx_ff;
   logic                          found_ff;
   logic [dvt_pkg::IDX_W-1:0]     hit_pos_ff;
   logic                          issue;
   logic                          hit;
   logic                          full;

   logic                          rsp_valid_ff;
   dvt_pkg::rsp_status_type       code_ff;
   dvt_pkg::rsp_status_type       code_in;
   logic [dvt_pkg::POS_W-1:0]     pos_ff;
   logic [dvt_pkg::IDX_W-1:0]     pos_in;
   logic [dvt_pkg::COUNT_W-1:0]   count_ff;
   logic [dvt_pkg::MEAN_W-1:0]    mean_ff;
   logic [dvt_pkg::MEAN_W-1:0]    mean_in;
   logic                          wr_en;

   logic                          div_done;
   logic [dvt_pkg::DIVD_W-1:0]    quotient;

   dvt_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend ({sum_ff, {dvt_pkg::FRAC_W{1'b0}}}),
      .divisor  (fill_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // scan: one read issued per cycle, compared in the cycle after
   assign issue = (rd_idx_ff < fill_ff);
   assign hit   = cmp_vld_ff && (rd_data_ff == value_ff);
   assign full  = (fill_ff == dvt_pkg::CNT_W'(dvt_pkg::TABLE_DEPTH));

   always_comb begin
      status.hit       = hit;
      status.scan_done = !cmp_vld_ff && !issue;
      status.empty     = (fill_ff == '0);
      status.div_done  = div_done;
      status.out_free  = !rsp_valid_ff || rsp_tready;
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_idx_ff[dvt_pkg::IDX_W-1:0]];
      if (cmd.finish && wr_en) begin
         mem[fill_ff[dvt_pkg::IDX_W-1:0]] <= value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= req_kind;
         value_ff <= req_value;
      end
      if (cmd.scan) begin
         cmp_idx_ff <= rd_idx_ff[dvt_pkg::IDX_W-1:0];
      end
      if (cmd.scan && hit) begin
         hit_pos_ff <= cmp_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff  <= '0;
         cmp_vld_ff <= 1'b0;
         found_ff   <= 1'b0;
      end else if (cmd.load) begin
         rd_idx_ff  <= '0;
         cmp_vld_ff <= 1'b0;
         found_ff   <= 1'b0;
      end else if (cmd.scan) begin
         cmp_vld_ff <= issue;
         if (issue) begin
            rd_idx_ff <= rd_idx_ff + 1'b1;
         end
         if (hit) begin
            found_ff <= 1'b1;
         end
      end
   end

   // result and table update for the request in hand
   always_comb begin
      code_in = dvt_pkg::ST_CLEARED;
      pos_in  = '0;
      mean_in = '0;
      fill_in = fill_ff;
      sum_in  = sum_ff;
      wr_en   = 1'b0;
      case (kind_ff)
         dvt_pkg::REQ_INSERT: begin
            if (found_ff) begin
               code_in = dvt_pkg::ST_DUPLICATE;
               pos_in  = hit_pos_ff;
            end else if (full) begin
               code_in = dvt_pkg::ST_FULL;
            end else begin
               code_in = dvt_pkg::ST_INSERTED;
               pos_in  = fill_ff[dvt_pkg::IDX_W-1:0];
               fill_in = fill_ff + 1'b1;
               sum_in  = sum_ff + dvt_pkg::SUM_W'(value_ff);
               wr_en   = 1'b1;
            end
         end
         dvt_pkg::REQ_SEARCH: begin
            if (found_ff) begin
               code_in = dvt_pkg::ST_FOUND;
               pos_in  = hit_pos_ff;
            end else begin
               code_in = dvt_pkg::ST_NOT_FOUND;
            end
         end
         dvt_pkg::REQ_MEAN: begin
            if (fill_ff == '0) begin
               code_in = dvt_pkg::ST_EMPTY;
            end else begin
               code_in = dvt_pkg::ST_MEAN_VALID;
               mean_in = quotient[dvt_pkg::MEAN_W-1:0];
            end
         end
         default: begin
            code_in = dvt_pkg::ST_CLEARED;
            fill_in = '0;
            sum_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         code_ff  <= code_in;
         pos_ff   <= dvt_pkg::POS_W'(pos_in);
         count_ff <= dvt_pkg::COUNT_W'(fill_in);
         mean_ff  <= mean_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = code_ff;
   assign rsp_tdata  = {{dvt_pkg::RSP_PAD_W{1'b0}}, mean_ff, count_ff, pos_ff};

   `DVT_ASSERT(a_finish_needs_room, cmd.finish |-> status.out_free, "result overwrote a pending transfer")
   `DVT_ASSERT(a_insert_grows, (cmd.finish && kind_ff == dvt_pkg::REQ_INSERT && !found_ff && !full) |=> (fill_ff == $past(fill_ff) + 1'b1), "insert did not grow the table")
   `DVT_ASSERT(a_hit_in_range, hit |-> ({1'b0, cmp_idx_ff} < fill_ff), "match outside filled entries")
   `DVT_ASSERT(a_div_for_mean, div_done |-> (kind_ff == dvt_pkg::REQ_MEAN), "divider finished outside a mean request")

endmodule

// ===== rtl/dvt_ctrl.sv =====
module dvt_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  dvt_pkg::req_kind_type      req_kind,
   input  dvt_pkg::dvt_status_type    status,
   output dvt_pkg::dvt_cmd_type       cmd
);

   dvt_pkg::ctrl_state_type state_ff;
   dvt_pkg::ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dvt_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dvt_pkg::S_IDLE: begin
            if (req_tvalid) begin
               if (req_kind inside {dvt_pkg::REQ_INSERT, dvt_pkg::REQ_SEARCH}) begin
                  state_in = dvt_pkg::S_SCAN;
               end else if (req_kind == dvt_pkg::REQ_MEAN && !status.empty) begin
                  state_in = dvt_pkg::S_DIVIDE;
               end else begin
                  state_in = dvt_pkg::S_FINISH;
               end
            end
         end
         dvt_pkg::S_SCAN: begin
            if (status.hit || status.scan_done) begin
               state_in = dvt_pkg::S_FINISH;
            end
         end
         dvt_pkg::S_DIVIDE: begin
            if (status.div_done) begin
               state_in = dvt_pkg::S_FINISH;
            end
         end
         dvt_pkg::S_FINISH: begin
            if (status.out_free) begin
               state_in = dvt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = dvt_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready    = (state_ff == dvt_pkg::S_IDLE);
      cmd.load      = (state_ff == dvt_pkg::S_IDLE) && req_tvalid;
      cmd.div_start = (state_ff == dvt_pkg::S_IDLE) && req_tvalid &&
                      (req_kind == dvt_pkg::REQ_MEAN) && !status.empty;
      cmd.scan      = (state_ff == dvt_pkg::S_SCAN);
      cmd.finish    = (state_ff == dvt_pkg::S_FINISH) && status.out_free;
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

   localparam int DRAIN_CYCLES = 60;
   localparam int PHASE_ITEMS  = 260;

   typedef struct {
      dvt_pkg::rsp_status_type            status;
      logic [dvt_pkg::POS_W-1:0]          position;
      logic [dvt_pkg::COUNT_W-1:0]        entry_count;
      logic [dvt_pkg::MEAN_W-1:0]         mean_q8;
   } rsp_item_type;

   // Tracks the table contents and holds the results still owed by the block
   class value_table_tracker;
      logic [dvt_pkg::VALUE_W-1:0] entries [dvt_pkg::TABLE_DEPTH];
      int                          fill;
      logic [63:0]                 sum;
      rsp_item_type                awaited_rsp [$];
      int                          errors;

      function new();
         fill   = 0;
         sum    = '0;
         errors = 0;
      endfunction

      // lowest index holding the value, -1 when absent
      function int find(logic [dvt_pkg::VALUE_W-1:0] value);
         for (int i = 0; i < fill; i++)
            if (entries[i] == value) return i;
         return -1;
      endfunction

      function void note_request(dvt_pkg::req_kind_type kind,
                                 logic [dvt_pkg::VALUE_W-1:0] value);
         rsp_item_type exp_rsp;
         int           hit;
         logic [63:0]  quot;
         exp_rsp.position = '0;
         exp_rsp.mean_q8  = '0;
         hit = find(value);
         case (kind)
            dvt_pkg::REQ_INSERT: begin
               if (hit >= 0) begin
                  exp_rsp.status   = dvt_pkg::ST_DUPLICATE;
                  exp_rsp.position = hit[dvt_pkg::POS_W-1:0];
               end else if (fill >= dvt_pkg::TABLE_DEPTH) begin
                  exp_rsp.status = dvt_pkg::ST_FULL;
               end else begin
                  entries[fill]    = value;
                  exp_rsp.position = fill[dvt_pkg::POS_W-1:0];
                  fill++;
                  sum += 64'(value);
                  exp_rsp.status = dvt_pkg::ST_INSERTED;
               end
            end
            dvt_pkg::REQ_SEARCH: begin
               if (hit >= 0) begin
                  exp_rsp.status   = dvt_pkg::ST_FOUND;
                  exp_rsp.position = hit[dvt_pkg::POS_W-1:0];
               end else begin
                  exp_rsp.status = dvt_pkg::ST_NOT_FOUND;
               end
            end
            dvt_pkg::REQ_MEAN: begin
               if (fill == 0) begin
                  exp_rsp.status = dvt_pkg::ST_EMPTY;
               end else begin
                  exp_rsp.status  = dvt_pkg::ST_MEAN_VALID;
                  quot            = (sum << dvt_pkg::FRAC_W) / 64'(fill);
                  exp_rsp.mean_q8 = quot[dvt_pkg::MEAN_W-1:0];
               end
            end
            default: begin
               fill           = 0;
               sum            = '0;
               exp_rsp.status = dvt_pkg::ST_CLEARED;
            end
         endcase
         exp_rsp.entry_count = fill[dvt_pkg::COUNT_W-1:0];
         awaited_rsp.push_back(exp_rsp);
      endfunction

      function void compare(string name, logic [63:0] exp_val, logic [63:0] act_val);
         if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
            errors++;
         end
      endfunction

      function void check_result(logic [dvt_pkg::RSP_USER_W-1:0] user,
                                 logic [dvt_pkg::RSP_DATA_W-1:0] data);
         rsp_item_type exp_rsp;
         if (awaited_rsp.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual status %0h data %0h",
                     $time, user, data);
            errors++;
            return;
         end
         exp_rsp = awaited_rsp.pop_front();
         compare("status", 64'(exp_rsp.status), 64'(user));
         compare("position", 64'(exp_rsp.position), 64'(data[dvt_pkg::POS_W-1:0]));
         compare("entry_count", 64'(exp_rsp.entry_count),
                 64'(data[dvt_pkg::POS_W +: dvt_pkg::COUNT_W]));
         compare("mean_q8", 64'(exp_rsp.mean_q8),
                 64'(data[dvt_pkg::POS_W+dvt_pkg::COUNT_W +: dvt_pkg::MEAN_W]));
         compare("padding", 64'd0,
                 64'(data[dvt_pkg::RSP_DATA_W-1 -: dvt_pkg::RSP_PAD_W]));
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [dvt_pkg::REQ_DATA_W-1:0] req_tdata;
   logic [dvt_pkg::REQ_USER_W-1:0] req_tuser;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [dvt_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [dvt_pkg::RSP_USER_W-1:0] rsp_tuser;

   value_table_tracker tracker = new();
   int idle_pct  = 0;
   int stall_pct = 0;
   int item_count = 0;

   distinct_value_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // result side: check every transfer, stall at random
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            tracker.check_result(rsp_tuser, rsp_tdata);
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   task automatic send_req(dvt_pkg::req_kind_type kind, logic [dvt_pkg::VALUE_W-1:0] value);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {1'b0, value};
      do @(posedge clock); while (!req_tready);
      tracker.note_request(kind, value);
      item_count++;
   endtask

   function automatic logic [dvt_pkg::VALUE_W-1:0] fresh_value(int pool);
      logic [dvt_pkg::VALUE_W-1:0] v;
      case (pool)
         0:       v = dvt_pkg::VALUE_W'($urandom_range(0, 63));
         1:       v = dvt_pkg::VALUE_W'($urandom());
         default: v = {dvt_pkg::VALUE_W{1'b1}} - dvt_pkg::VALUE_W'($urandom_range(0, 255));
      endcase
      return v;
   endfunction

   // clear, fill with a mix of new and repeated values, probe along the way
   task automatic run_episode();
      logic [dvt_pkg::VALUE_W-1:0] seen [$];
      logic [dvt_pkg::VALUE_W-1:0] v;
      int pool;
      int n_ins;
      int r;
      pool  = $urandom_range(0, 2);
      n_ins = ($urandom_range(0, 2) == 0) ? $urandom_range(32, 44) : $urandom_range(1, 31);
      send_req(dvt_pkg::REQ_CLEAR, dvt_pkg::VALUE_W'($urandom()));
      for (int i = 0; i < n_ins; i++) begin
         if (seen.size() != 0 && $urandom_range(0, 99) < 20)
            v = seen[$urandom_range(0, seen.size() - 1)];
         else
            v = fresh_value(pool);
         seen.push_back(v);
         send_req(dvt_pkg::REQ_INSERT, v);
         r = $urandom_range(0, 99);
         if (r < 15)
            send_req(dvt_pkg::REQ_SEARCH, seen[$urandom_range(0, seen.size() - 1)]);
         else if (r < 22)
            send_req(dvt_pkg::REQ_SEARCH, fresh_value(pool));
         else if (r < 30)
            send_req(dvt_pkg::REQ_MEAN, dvt_pkg::VALUE_W'($urandom()));
         else if (r < 32)
            send_req(dvt_pkg::REQ_CLEAR, dvt_pkg::VALUE_W'($urandom()));
      end
      send_req(dvt_pkg::REQ_MEAN, dvt_pkg::VALUE_W'($urandom()));
      send_req(dvt_pkg::REQ_INSERT, seen[$urandom_range(0, seen.size() - 1)]);
      send_req(dvt_pkg::REQ_INSERT, fresh_value(pool));
      send_req(dvt_pkg::REQ_SEARCH, seen[$urandom_range(0, seen.size() - 1)]);
      send_req(dvt_pkg::REQ_SEARCH, fresh_value(pool));
   endtask

   initial begin
      int start;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= dvt_pkg::REQ_INSERT;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, extremes, duplicates, stale entries after clear
      send_req(dvt_pkg::REQ_MEAN,   '0);
      send_req(dvt_pkg::REQ_SEARCH, '0);
      send_req(dvt_pkg::REQ_CLEAR,  '0);
      send_req(dvt_pkg::REQ_INSERT, '0);
      send_req(dvt_pkg::REQ_INSERT, {dvt_pkg::VALUE_W{1'b1}});
      send_req(dvt_pkg::REQ_INSERT, '0);
      send_req(dvt_pkg::REQ_SEARCH, {dvt_pkg::VALUE_W{1'b1}});
      send_req(dvt_pkg::REQ_SEARCH, 31'd1);
      send_req(dvt_pkg::REQ_MEAN,   '0);
      send_req(dvt_pkg::REQ_INSERT, 31'h5555_5555);
      send_req(dvt_pkg::REQ_INSERT, 31'h2AAA_AAAA);
      send_req(dvt_pkg::REQ_INSERT, {dvt_pkg::VALUE_W{1'b1}});
      send_req(dvt_pkg::REQ_MEAN,   {dvt_pkg::VALUE_W{1'b1}});
      send_req(dvt_pkg::REQ_CLEAR,  {dvt_pkg::VALUE_W{1'b1}});
      send_req(dvt_pkg::REQ_MEAN,   '0);
      send_req(dvt_pkg::REQ_SEARCH, '0);
      send_req(dvt_pkg::REQ_INSERT, 31'd5);
      send_req(dvt_pkg::REQ_SEARCH, 31'd5);
      send_req(dvt_pkg::REQ_INSERT, 31'd5);
      send_req(dvt_pkg::REQ_MEAN,   '0);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 47; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 47; end
            default: begin idle_pct = 10; stall_pct = 10; end
         endcase
         start = item_count;
         while (item_count - start < PHASE_ITEMS)
            run_episode();
      end
      req_tvalid <= 1'b0;

      while (tracker.awaited_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tracker.awaited_rsp.size() != 0) begin
         $display("%0t: results missing, expected %0d more, actual 0",
                  $time, tracker.awaited_rsp.size());
         tracker.errors++;
      end
      if (tracker.errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule

// ===== distinct_value_table.f =====
+incdir+rtl
rtl/dvt_pkg.sv
rtl/dvt_divider.sv
rtl/dvt_datapath.sv
rtl/dvt_ctrl.sv
rtl/distinct_value_table.sv
tb/tb.sv
